// ===== src/tnsp_pkg.sv =====
// ============================================================================
// tnsp_pkg
// Shared widths, constants and payload types of the sphere projection unit.
// ============================================================================
package tnsp_pkg;

    localparam int VtxW     = 24;   // vertex coordinate, Q4.20
    localparam int RefW     = 18;   // reference coordinate, Q1.16
    localparam int OutW     = 24;   // unit-vector component, Q1.22
    localparam int WgtW     = 20;   // doubled barycentric weight, Q.16
    localparam int ProdW    = 44;   // weight times vertex
    localparam int SumW     = 47;   // signed sum of three products
    localparam int MagW     = 46;   // magnitude of the sum
    localparam int ShiftW   = 6;    // bit length and shift amount
    localparam int NormW    = 30;   // normalized magnitude
    localparam int SqW      = 62;   // sum of three squares
    localparam int RootW    = 31;   // integer square root
    localparam int RemW     = 33;   // square-root partial remainder
    localparam int FracBits = 22;   // output fraction bits
    localparam int NumW     = NormW + FracBits + 1;
    localparam int QuoW     = 24;   // quotient bits produced by the divider
    localparam int HeadW    = NumW - QuoW;

    localparam int OneQ16 = 65536;
    localparam logic [QuoW-1:0] OneQ22 = QuoW'(4194304);

    localparam int MapStages  = 7;
    localparam int SqrtStages = RootW;
    localparam int DivStages  = QuoW + 2;

    // one node request: vert[axis][vertex], axis 0..2 = x, y, z
    typedef struct packed {
        logic [2:0][2:0][VtxW-1:0] vert;
        logic [RefW-1:0]           ref_r;
        logic [RefW-1:0]           ref_s;
    } node_t;

    // normalized magnitudes with their signs
    typedef struct packed {
        logic [2:0][NormW-1:0] mag;
        logic [2:0]            neg;
        logic                  degen;
    } norm_t;

    typedef struct packed {
        logic [2:0][OutW-1:0] unit;
        logic                 degenerate;
    } res_t;

endpackage

// ===== src/tnsp_node_if.sv =====
// ============================================================================
// tnsp_node_if
// Request channel: three triangle vertices and one reference node.
// ============================================================================
interface tnsp_node_if;
    logic                            valid;
    logic                            ready;
    logic signed [tnsp_pkg::VtxW-1:0] vert1_x;
    logic signed [tnsp_pkg::VtxW-1:0] vert2_x;
    logic signed [tnsp_pkg::VtxW-1:0] vert3_x;
    logic signed [tnsp_pkg::VtxW-1:0] vert1_y;
    logic signed [tnsp_pkg::VtxW-1:0] vert2_y;
    logic signed [tnsp_pkg::VtxW-1:0] vert3_y;
    logic signed [tnsp_pkg::VtxW-1:0] vert1_z;
    logic signed [tnsp_pkg::VtxW-1:0] vert2_z;
    logic signed [tnsp_pkg::VtxW-1:0] vert3_z;
    logic signed [tnsp_pkg::RefW-1:0] ref_r;
    logic signed [tnsp_pkg::RefW-1:0] ref_s;

    modport source (output valid, vert1_x, vert2_x, vert3_x, vert1_y, vert2_y, vert3_y,
                    vert1_z, vert2_z, vert3_z, ref_r, ref_s, input ready);
    modport sink   (input valid, vert1_x, vert2_x, vert3_x, vert1_y, vert2_y, vert3_y,
                    vert1_z, vert2_z, vert3_z, ref_r, ref_s, output ready);
endinterface

// ===== src/tnsp_result_if.sv =====
// ============================================================================
// tnsp_result_if
// Result channel: unit-vector components and the degenerate flag.
// ============================================================================
interface tnsp_result_if;
    logic                             valid;
    logic                             ready;
    logic signed [tnsp_pkg::OutW-1:0] unit_x;
    logic signed [tnsp_pkg::OutW-1:0] unit_y;
    logic signed [tnsp_pkg::OutW-1:0] unit_z;
    logic                             degenerate;

    modport source (output valid, unit_x, unit_y, unit_z, degenerate, input ready);
    modport sink   (input valid, unit_x, unit_y, unit_z, degenerate, output ready);
endinterface

// ===== src/tnsp_map.sv =====
// ============================================================================
// tnsp_map
// Affine map, magnitudes, leading-one search, normalizing shift and squares.
// ============================================================================
module tnsp_map (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  tnsp_pkg::node_t            in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [tnsp_pkg::SqW-1:0]   out_rad,
    output tnsp_pkg::norm_t            out_side
);

    localparam int NS = tnsp_pkg::MapStages;

    logic [NS-1:0] vld_reg, vld_next;
    logic [NS:0]   en;

    logic signed [tnsp_pkg::ProdW-1:0] prod_reg [3][3];
    logic signed [tnsp_pkg::ProdW-1:0] prod_next [3][3];
    logic [tnsp_pkg::MagW-1:0]  mag1_reg [3], mag1_next [3];
    logic [2:0]                 neg1_reg, neg1_next;
    logic [tnsp_pkg::MagW-1:0]  mag2_reg [3];
    logic [2:0]                 neg2_reg;
    logic [tnsp_pkg::MagW-1:0]  or2_reg, or2_next;
    logic [tnsp_pkg::MagW-1:0]  mag3_reg [3];
    logic [2:0]                 neg3_reg;
    logic [tnsp_pkg::ShiftW-1:0] amt3_reg, amt3_next;
    logic                       rsh3_reg, rsh3_next;
    logic                       degen3_reg, degen3_next;
    tnsp_pkg::norm_t            side4_reg, side4_next;
    logic [2*tnsp_pkg::NormW-1:0] sq5_reg [3], sq5_next [3];
    tnsp_pkg::norm_t            side5_reg;
    logic [tnsp_pkg::SqW-1:0]   rad6_reg, rad6_next;
    tnsp_pkg::norm_t            side6_reg;

    // stage enables: a stage loads when empty or when its successor moves
    always_comb
    begin
        en[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        for (int k = 0; k < NS; k++)
        begin
            if (en[k])
                vld_next[k] = (k == 0) ? in_valid : vld_reg[k-1];
            else
                vld_next[k] = vld_reg[k];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NS-1];

    // stage 0: doubled weights times vertices
    always_comb
    begin
        logic signed [tnsp_pkg::WgtW-1:0]  r_ext, s_ext;
        logic signed [tnsp_pkg::WgtW-1:0]  wgt [3];
        logic signed [tnsp_pkg::ProdW-1:0] wx, vx;
        r_ext  = tnsp_pkg::WgtW'($signed(in_data.ref_r));
        s_ext  = tnsp_pkg::WgtW'($signed(in_data.ref_s));
        wgt[0] = -(r_ext + s_ext);
        wgt[1] = tnsp_pkg::WgtW'(tnsp_pkg::OneQ16) + r_ext;
        wgt[2] = tnsp_pkg::WgtW'(tnsp_pkg::OneQ16) + s_ext;
        for (int a = 0; a < 3; a++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                wx = tnsp_pkg::ProdW'(wgt[k]);
                vx = tnsp_pkg::ProdW'($signed(in_data.vert[a][k]));
                prod_next[a][k] = wx * vx;
            end
        end
    end

    // stage 1: sum per axis, split sign and magnitude
    always_comb
    begin
        logic signed [tnsp_pkg::SumW-1:0] p, pa;
        for (int a = 0; a < 3; a++)
        begin
            p = tnsp_pkg::SumW'(prod_reg[a][0]) + tnsp_pkg::SumW'(prod_reg[a][1])
              + tnsp_pkg::SumW'(prod_reg[a][2]);
            neg1_next[a] = p[tnsp_pkg::SumW-1];
            pa = neg1_next[a] ? -p : p;
            mag1_next[a] = pa[tnsp_pkg::MagW-1:0];
        end
    end

    // stage 2: the largest magnitude has the same bit length as the OR of all
    assign or2_next = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];

    // stage 3: leading-one search and shift direction
    always_comb
    begin
        logic [tnsp_pkg::ShiftW-1:0] bl;
        bl = '0;
        for (int i = 0; i < tnsp_pkg::MagW; i++)
        begin
            if (or2_reg[i])
                bl = tnsp_pkg::ShiftW'(i + 1);
        end
        degen3_next = (or2_reg == '0);
        rsh3_next   = (bl > tnsp_pkg::ShiftW'(tnsp_pkg::NormW));
        amt3_next   = rsh3_next ? bl - tnsp_pkg::ShiftW'(tnsp_pkg::NormW)
                                : tnsp_pkg::ShiftW'(tnsp_pkg::NormW) - bl;
    end

    // stage 4: normalizing shift
    always_comb
    begin
        logic [tnsp_pkg::MagW-1:0] sh;
        for (int a = 0; a < 3; a++)
        begin
            sh = rsh3_reg ? (mag3_reg[a] >> amt3_reg) : (mag3_reg[a] << amt3_reg);
            side4_next.mag[a] = sh[tnsp_pkg::NormW-1:0];
        end
        side4_next.neg   = neg3_reg;
        side4_next.degen = degen3_reg;
    end

    // stage 5: squares
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            sq5_next[a] = (2*tnsp_pkg::NormW)'(side4_reg.mag[a]) *
                          (2*tnsp_pkg::NormW)'(side4_reg.mag[a]);
        end
    end

    // stage 6: sum of squares
    assign rad6_next = tnsp_pkg::SqW'(sq5_reg[0]) + tnsp_pkg::SqW'(sq5_reg[1])
                     + tnsp_pkg::SqW'(sq5_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // advance payload of each stage that loads
    always_ff @(posedge clk)
    begin
        if (en[0])
            prod_reg <= prod_next;
        if (en[1])
        begin
            mag1_reg <= mag1_next;
            neg1_reg <= neg1_next;
        end
        if (en[2])
        begin
            mag2_reg <= mag1_reg;
            neg2_reg <= neg1_reg;
            or2_reg  <= or2_next;
        end
        if (en[3])
        begin
            mag3_reg   <= mag2_reg;
            neg3_reg   <= neg2_reg;
            amt3_reg   <= amt3_next;
            rsh3_reg   <= rsh3_next;
            degen3_reg <= degen3_next;
        end
        if (en[4])
            side4_reg <= side4_next;
        if (en[5])
        begin
            sq5_reg   <= sq5_next;
            side5_reg <= side4_reg;
        end
        if (en[6])
        begin
            rad6_reg  <= rad6_next;
            side6_reg <= side5_reg;
        end
    end

    assign out_rad  = rad6_reg;
    assign out_side = side6_reg;

endmodule

// ===== src/tnsp_sqrt.sv =====
// ============================================================================
// tnsp_sqrt
// Pipelined integer square root, one result bit per stage.
// ============================================================================
module tnsp_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [tnsp_pkg::SqW-1:0]   in_rad,
    input  tnsp_pkg::norm_t            in_side,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [tnsp_pkg::RootW-1:0] out_root,
    output tnsp_pkg::norm_t            out_side
);

    localparam int NS = tnsp_pkg::SqrtStages;

    logic [NS-1:0] vld_reg, vld_next;
    logic [NS:0]   en;

    logic [tnsp_pkg::RemW-1:0]  rem_reg  [NS];
    logic [tnsp_pkg::RootW-1:0] root_reg [NS];
    logic [tnsp_pkg::SqW-1:0]   rad_reg  [NS];
    tnsp_pkg::norm_t            side_reg [NS];

    // stage enables
    always_comb
    begin
        en[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        for (int k = 0; k < NS; k++)
        begin
            if (en[k])
                vld_next[k] = (k == 0) ? in_valid : vld_reg[k-1];
            else
                vld_next[k] = vld_reg[k];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    for (genvar j = 0; j < NS; j++)
    begin : g_step
        logic [tnsp_pkg::RemW-1:0]  rem_prev;
        logic [tnsp_pkg::RootW-1:0] root_prev;
        logic [tnsp_pkg::SqW-1:0]   rad_prev;
        tnsp_pkg::norm_t            side_prev;
        logic [tnsp_pkg::RemW+1:0]  cat, trial;
        logic                       take;

        if (j == 0)
        begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = in_rad;
            assign side_prev = in_side;
        end
        else
        begin : g_rest
            assign rem_prev  = rem_reg[j-1];
            assign root_prev = root_reg[j-1];
            assign rad_prev  = rad_reg[j-1];
            assign side_prev = side_reg[j-1];
        end

        // bring down the next bit pair and try the next root bit
        assign cat   = {rem_prev, rad_prev[tnsp_pkg::SqW-1-2*j -: 2]};
        assign trial = {2'b00, root_prev, 2'b01};
        assign take  = (cat >= trial);

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                rem_reg[j]  <= take ? tnsp_pkg::RemW'(cat - trial) : tnsp_pkg::RemW'(cat);
                root_reg[j] <= {root_prev[tnsp_pkg::RootW-2:0], take};
                rad_reg[j]  <= rad_prev;
                side_reg[j] <= side_prev;
            end
        end
    end

    assign out_root = root_reg[NS-1];
    assign out_side = side_reg[NS-1];

    // the largest normalized magnitude has its top bit set, so the root is at least 2**29
    a_root_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_side.degen |-> out_root[tnsp_pkg::RootW-2] || out_root[tnsp_pkg::RootW-1])
        else $error("square root below normalized range");

endmodule

// ===== src/tnsp_div.sv =====
// ============================================================================
// tnsp_div
// Three-lane pipelined rounding divider with saturation and sign restore.
// ============================================================================
module tnsp_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [tnsp_pkg::RootW-1:0] in_root,
    input  tnsp_pkg::norm_t            in_side,
    output logic                       out_valid,
    input  logic                       out_ready,
    output tnsp_pkg::res_t             out_res
);

    localparam int NS = tnsp_pkg::DivStages;
    localparam int NQ = tnsp_pkg::QuoW;

    logic [NS-1:0] vld_reg, vld_next;
    logic [NS:0]   en;

    // stages 0..NQ hold the long division, stage NQ+1 the result
    logic [tnsp_pkg::RootW-1:0] rem_reg  [NQ+1][3];
    logic [NQ-1:0]              low_reg  [NQ+1][3];
    logic [NQ-1:0]              quo_reg  [NQ+1][3];
    logic [tnsp_pkg::RootW-1:0] div_reg  [NQ+1];
    logic [2:0]                 neg_reg  [NQ+1];
    logic                       dgn_reg  [NQ+1];
    tnsp_pkg::res_t             res_reg, res_next;

    // stage enables
    always_comb
    begin
        en[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        for (int k = 0; k < NS; k++)
        begin
            if (en[k])
                vld_next[k] = (k == 0) ? in_valid : vld_reg[k-1];
            else
                vld_next[k] = vld_reg[k];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // stage 0: numerator with half the divisor added for rounding
    always_ff @(posedge clk)
    begin
        logic [tnsp_pkg::NumW-1:0] num;
        if (en[0])
        begin
            for (int l = 0; l < 3; l++)
            begin
                num = tnsp_pkg::NumW'({in_side.mag[l], tnsp_pkg::FracBits'(0)})
                    + tnsp_pkg::NumW'(in_root >> 1);
                rem_reg[0][l] <= tnsp_pkg::RootW'(num[tnsp_pkg::NumW-1 -: tnsp_pkg::HeadW]);
                low_reg[0][l] <= num[NQ-1:0];
                quo_reg[0][l] <= '0;
            end
            div_reg[0] <= in_root;
            neg_reg[0] <= in_side.neg;
            dgn_reg[0] <= in_side.degen;
        end
    end

    // stages 1..NQ: one quotient bit each
    for (genvar k = 1; k <= NQ; k++)
    begin : g_step
        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            logic [tnsp_pkg::RootW:0] cat;
            logic                     ge;
            assign cat = {rem_reg[k-1][l], low_reg[k-1][l][NQ-1]};
            assign ge  = (cat >= {1'b0, div_reg[k-1]});

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    rem_reg[k][l] <= ge ? tnsp_pkg::RootW'(cat - {1'b0, div_reg[k-1]})
                                        : cat[tnsp_pkg::RootW-1:0];
                    low_reg[k][l] <= {low_reg[k-1][l][NQ-2:0], 1'b0};
                    quo_reg[k][l] <= {quo_reg[k-1][l][NQ-2:0], ge};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                div_reg[k] <= div_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                dgn_reg[k] <= dgn_reg[k-1];
            end
        end
    end

    // last stage: saturate to one, restore sign, zero a degenerate point
    always_comb
    begin
        logic [NQ-1:0] q;
        for (int l = 0; l < 3; l++)
        begin
            q = (quo_reg[NQ][l] > tnsp_pkg::OneQ22) ? tnsp_pkg::OneQ22 : quo_reg[NQ][l];
            if (dgn_reg[NQ])
                res_next.unit[l] = '0;
            else if (neg_reg[NQ][l])
                res_next.unit[l] = tnsp_pkg::OutW'(-q);
            else
                res_next.unit[l] = tnsp_pkg::OutW'(q);
        end
        res_next.degenerate = dgn_reg[NQ];
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
            res_reg <= res_next;
    end

    assign out_res = res_reg;

endmodule

// ===== src/triangle_node_sphere_projection_unit.sv =====
// ============================================================================
// triangle_node_sphere_projection_unit
// Maps a reference node into a triangle and projects it onto the unit sphere.
// ============================================================================
// Usage:
//   node   : request channel (valid/ready) with three vertices in Q4.20 and the
//            node coordinates r, s in Q1.16.
//   result : one result per request: unit_x/y/z in Q1.22, saturated to +-1,
//            rounded half away from zero, and a degenerate flag that is set
//            (with zero components) when the mapped point is the origin.
//   From request to result the pipeline has 7 map and normalize stages,
//   31 square-root stages (one root bit each) and 26 divider stages
//   (24 quotient bits plus setup and saturation).
//   Throughput is one request per cycle until a stall fills the pipeline;
//   every stage is a pipeline register with its own valid bit.
//   When the receiver stalls, the last stage holds its result and the stages
//   behind it keep filling any empty slots, so requests are still taken until
//   the whole pipeline is full; then node.ready drops.
//   Reset clears all valid bits; the pipeline is empty and ready afterwards.
// ============================================================================
module triangle_node_sphere_projection_unit (
    input  logic          clk,
    input  logic          rst_n,
    tnsp_node_if.sink     node,
    tnsp_result_if.source result
);

    tnsp_pkg::node_t node_data;
    logic            map_valid, map_ready;
    logic [tnsp_pkg::SqW-1:0] map_rad;
    tnsp_pkg::norm_t map_side;
    logic            sqrt_valid, sqrt_ready;
    logic [tnsp_pkg::RootW-1:0] sqrt_root;
    tnsp_pkg::norm_t sqrt_side;
    tnsp_pkg::res_t  res;

    // pack the request payload, vert[axis][vertex]
    assign node_data.vert[0][0] = node.vert1_x;
    assign node_data.vert[0][1] = node.vert2_x;
    assign node_data.vert[0][2] = node.vert3_x;
    assign node_data.vert[1][0] = node.vert1_y;
    assign node_data.vert[1][1] = node.vert2_y;
    assign node_data.vert[1][2] = node.vert3_y;
    assign node_data.vert[2][0] = node.vert1_z;
    assign node_data.vert[2][1] = node.vert2_z;
    assign node_data.vert[2][2] = node.vert3_z;
    assign node_data.ref_r      = node.ref_r;
    assign node_data.ref_s      = node.ref_s;

    tnsp_map u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (node.valid),
        .in_ready  (node.ready),
        .in_data   (node_data),
        .out_valid (map_valid),
        .out_ready (map_ready),
        .out_rad   (map_rad),
        .out_side  (map_side)
    );

    tnsp_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (map_valid),
        .in_ready  (map_ready),
        .in_rad    (map_rad),
        .in_side   (map_side),
        .out_valid (sqrt_valid),
        .out_ready (sqrt_ready),
        .out_root  (sqrt_root),
        .out_side  (sqrt_side)
    );

    tnsp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sqrt_valid),
        .in_ready  (sqrt_ready),
        .in_root   (sqrt_root),
        .in_side   (sqrt_side),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_res   (res)
    );

    assign result.unit_x     = res.unit[0];
    assign result.unit_y     = res.unit[1];
    assign result.unit_z     = res.unit[2];
    assign result.degenerate = res.degenerate;

    // a degenerate point leaves all components at zero
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.degenerate |->
            result.unit_x == '0 && result.unit_y == '0 && result.unit_z == '0)
        else $error("degenerate result with nonzero components");

    // components never pass plus or minus one
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |->
            result.unit_x <= 24'sd4194304 && result.unit_x >= -24'sd4194304 &&
            result.unit_y <= 24'sd4194304 && result.unit_y >= -24'sd4194304 &&
            result.unit_z <= 24'sd4194304 && result.unit_z >= -24'sd4194304)
        else $error("unit component out of range");

    // requests are refused only when the pipeline is full behind a stalled result
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !node.ready |-> result.valid && !result.ready)
        else $error("request refused with room in the pipeline");

endmodule

// ===== bench/triangle_node_sphere_projection_unit_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// triangle_node_sphere_projection_unit_tb
// Self-checking bench: drives node requests under random idling and stalls,
// predicts each unit vector bit for bit and compares every result in order.
// ============================================================================
module triangle_node_sphere_projection_unit_tb;

    typedef struct {
        logic signed [tnsp_pkg::VtxW-1:0] v [9];   // x1 x2 x3 y1 y2 y3 z1 z2 z3
        logic signed [tnsp_pkg::RefW-1:0] r;
        logic signed [tnsp_pkg::RefW-1:0] s;
    } node_req_t;

    typedef struct {
        logic [tnsp_pkg::OutW-1:0] u [3];
        logic                      degen;
    } unit_vec_t;

    localparam int WatchLimit = 20000;

    logic clk;
    logic rst_n;

    tnsp_node_if   node_ch ();
    tnsp_result_if res_ch ();

    triangle_node_sphere_projection_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .node   (node_ch.sink),
        .result (res_ch.source)
    );

    unit_vec_t expected_units [$];
    int        mismatches;
    int        results_seen;
    int        degen_seen;
    int        sat_seen;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        recv_hold;
    int        quiet_cycles;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Integer square root, bit by bit
    function automatic longint unsigned root64(longint unsigned a);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > a)
            b >>= 2;
        while (b != 0)
        begin
            if (a >= res + b)
            begin
                a  -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // Map the node into the triangle and project onto the unit sphere
    function automatic unit_vec_t project_node(node_req_t n);
        unit_vec_t       o;
        longint          w1, w2, w3, p;
        longint unsigned mag [3];
        logic            neg [3];
        longint unsigned m, sum, len, q;
        int              bl;
        w1  = -(longint'(n.r) + longint'(n.s));
        w2  = tnsp_pkg::OneQ16 + longint'(n.r);
        w3  = tnsp_pkg::OneQ16 + longint'(n.s);
        m   = 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            p = w1 * longint'(n.v[3*i]) + w2 * longint'(n.v[3*i+1])
                + w3 * longint'(n.v[3*i+2]);
            neg[i] = p < 0;
            mag[i] = neg[i] ? longint'(-p) : p;
            if (mag[i] > m)
                m = mag[i];
        end
        o.degen = (m == 0);
        for (int i = 0; i < 3; i++)
            o.u[i] = '0;
        if (m == 0)
            return o;
        bl = 0;
        while ((m >> bl) != 0)
            bl++;
        for (int i = 0; i < 3; i++)
        begin
            if (bl > tnsp_pkg::NormW)
                mag[i] >>= (bl - tnsp_pkg::NormW);
            else
                mag[i] <<= (tnsp_pkg::NormW - bl);
            sum += mag[i] * mag[i];
        end
        len = root64(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((mag[i] << tnsp_pkg::FracBits) + (len >> 1)) / len;
            if (q > 64'd4194304)
                q = 64'd4194304;
            if (neg[i])
                q = -q;
            o.u[i] = q[tnsp_pkg::OutW-1:0];
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [tnsp_pkg::OutW-1:0] got,
                                   logic [tnsp_pkg::OutW-1:0] exp);
        mismatches++;
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, exp);
    endtask

    // Offer one request, with random idle cycles first, until accepted
    task automatic send_node(node_req_t n);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            node_ch.valid <= 1'b0;
            @(posedge clk);
        end
        node_ch.valid   <= 1'b1;
        node_ch.vert1_x <= n.v[0];
        node_ch.vert2_x <= n.v[1];
        node_ch.vert3_x <= n.v[2];
        node_ch.vert1_y <= n.v[3];
        node_ch.vert2_y <= n.v[4];
        node_ch.vert3_y <= n.v[5];
        node_ch.vert1_z <= n.v[6];
        node_ch.vert2_z <= n.v[7];
        node_ch.vert3_z <= n.v[8];
        node_ch.ref_r   <= n.r;
        node_ch.ref_s   <= n.s;
        @(posedge clk);
        while (!node_ch.ready)
            @(posedge clk);
        expected_units.push_back(project_node(n));
    endtask

    task automatic wait_drained();
        node_ch.valid <= 1'b0;
        while (expected_units.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [tnsp_pkg::RefW-1:0] rand_ref();
        case ($urandom_range(9, 0))
            0: return -18'sd65536;
            1: return 18'sd65536;
            2: return 18'($urandom);   // any pattern, out of range too
            default: return 18'($signed($urandom_range(131072, 0)) - 65536);
        endcase
    endfunction

    function automatic logic signed [tnsp_pkg::VtxW-1:0] rand_vtx();
        case ($urandom_range(7, 0))
            0: return 24'sh7fffff;
            1: return 24'sh800000;
            2: return 24'($signed($urandom_range(64, 0)) - 32);
            3: return 24'sh100000 + 24'($urandom_range(255, 0));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic node_req_t rand_node();
        node_req_t n;
        for (int i = 0; i < 9; i++)
            n.v[i] = rand_vtx();
        n.r = rand_ref();
        n.s = rand_ref();
        // triangle of coincident vertices
        if ($urandom_range(19, 0) == 0)
            for (int i = 0; i < 9; i++)
                n.v[i] = (i % 3 == 0) ? n.v[i] : n.v[i - i % 3];
        return n;
    endfunction

    // Directed: extremes, degenerate points, corner nodes, saturation
    task automatic test_directed();
        node_req_t n;
        for (int k = 0; k < 22; k++)
        begin
            for (int i = 0; i < 9; i++)
                n.v[i] = '0;
            n.r = '0;
            n.s = '0;
            case (k)
                0: ;
                1:  for (int i = 0; i < 9; i++) n.v[i] = 24'sh7fffff;
                2:  for (int i = 0; i < 9; i++) n.v[i] = 24'sh800000;
                3:  begin n.v[0] = 24'sh100000; n.r = -18'sd65536; n.s = -18'sd65536; end
                4:  begin n.v[1] = 24'sh100000; n.r = 18'sd65536; n.s = -18'sd65536; end
                5:  begin n.v[5] = -24'sh100000; n.r = -18'sd65536; n.s = 18'sd65536; end
                6:  begin n.v[8] = 24'sd1; n.r = -18'sd65536; n.s = 18'sd65536; end
                7:  begin n.v[0] = 24'sd1; n.v[3] = 24'sd1; n.v[6] = 24'sd1; end
                8:  begin n.v[0] = 24'sd3; n.v[1] = 24'sd3; n.v[2] = 24'sd3; n.r = 18'sd65536;
                          n.s = 18'sd65536; end   // equal x vertices, the point lies on the x axis
                9:  for (int i = 0; i < 9; i++) n.v[i] = (i < 3) ? 24'sh7fffff : 24'sh800000;
                10: begin for (int i = 0; i < 9; i++) n.v[i] = 24'sh7fffff;
                          n.r = 18'sh1ffff; n.s = 18'sh20000; end  // out-of-range refs
                11: begin for (int i = 0; i < 9; i++) n.v[i] = 24'sh800000;
                          n.r = 18'sd65536; n.s = 18'sd65536; end
                12: begin n.v[0] = 24'sd1; n.v[1] = 24'sd1; n.v[2] = 24'sd1; end
                13: begin n.v[3] = -24'sd1; n.v[4] = -24'sd1; n.v[5] = -24'sd1; end
                14: begin n.v[6] = 24'sh7fffff; n.v[7] = 24'sh7fffff; n.v[8] = 24'sh7fffff;
                          n.v[0] = 24'sd1; end
                default: n = rand_node();
            endcase
            send_node(n);
        end
        wait_drained();
    endtask

    task automatic test_random(int count);
        for (int k = 0; k < count; k++)
            send_node(rand_node());
    endtask

    // Receiver holds off while the sender keeps offering, filling the pipe
    task automatic test_backpressure();
        recv_hold = 300;
        test_random(120);
        wait_drained();
    endtask

    // Ready: random idling, plus a long hold-off counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (recv_hold > 0)
        begin
            recv_hold    <= recv_hold - 1;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
    end

    // Check each accepted result against the oldest prediction
    always @(posedge clk)
    begin
        unit_vec_t e;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_seen++;
            if (expected_units.size() == 0)
            begin
                mismatches++;
                $display("mismatch at %0t: result with nothing expected", $realtime);
            end
            else
            begin
                e = expected_units.pop_front();
                if (e.degen)
                    degen_seen++;
                if (e.u[0] == 24'h400000 || e.u[0] == 24'hc00000)
                    sat_seen++;
                if (res_ch.unit_x !== e.u[0]) report_mismatch("unit_x", res_ch.unit_x, e.u[0]);
                if (res_ch.unit_y !== e.u[1]) report_mismatch("unit_y", res_ch.unit_y, e.u[1]);
                if (res_ch.unit_z !== e.u[2]) report_mismatch("unit_z", res_ch.unit_z, e.u[2]);
                if (res_ch.degenerate !== e.degen)
                    report_mismatch("degenerate", tnsp_pkg::OutW'(res_ch.degenerate),
                                    tnsp_pkg::OutW'(e.degen));
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((node_ch.valid && node_ch.ready) || (res_ch.valid && res_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchLimit)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        mismatches    = 0;
        results_seen  = 0;
        degen_seen    = 0;
        sat_seen      = 0;
        quiet_cycles  = 0;
        recv_hold     = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n         = 1'b0;
        node_ch.valid   = 1'b0;
        node_ch.vert1_x = '0;
        node_ch.vert2_x = '0;
        node_ch.vert3_x = '0;
        node_ch.vert1_y = '0;
        node_ch.vert2_y = '0;
        node_ch.vert3_y = '0;
        node_ch.vert1_z = '0;
        node_ch.vert2_z = '0;
        node_ch.vert3_z = '0;
        node_ch.ref_r   = '0;
        node_ch.ref_s   = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 16;
        recv_idle_pct = 74;
        test_directed();
        test_random(260);
        test_backpressure();
        send_idle_pct = 74;
        recv_idle_pct = 16;
        test_random(260);
        wait_drained();   // sender pauses until everything has come back
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(290);
        wait_drained();
        repeat (80) @(posedge clk);

        $display("tb: %0d results checked, %0d degenerate, %0d saturated x, %0d mismatches",
                 results_seen, degen_seen, sat_seen, mismatches);
        $display("tb: covered vertex extremes, corner nodes, out-of-range refs and stalls");
        if (mismatches == 0 && expected_units.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== files.f =====
src/tnsp_pkg.sv
src/tnsp_node_if.sv
src/tnsp_result_if.sv
src/tnsp_map.sv
src/tnsp_sqrt.sv
src/tnsp_div.sv
src/triangle_node_sphere_projection_unit.sv
bench/triangle_node_sphere_projection_unit_tb.sv
